// ===== rtl/bgl_pkg.sv =====
// Beat grid line generator: shared widths, register and kind codes, payload types.
// Used by every module of the block but bgl_fifo; depends on nothing.
package bgl_pkg;

  localparam int SAMPLE_BITS   = 48;
  localparam int SPB_FRAC_BITS = 16;
  localparam int SPB_W         = 40;
  localparam int DIV_W         = 8;
  localparam int BPB_W         = 5;
  localparam int MOD_W         = 13;   // division * beats_per_bar <= 255 * 31
  localparam int MAX_LINES_DEF = 64;
  localparam int FIFO_DEPTH    = 2;

  localparam int DEN_W  = DIV_W + SPB_FRAC_BITS;
  localparam int XW     = SPB_W + 7;              // r + 64 * spb
  localparam int FX_W   = XW - SPB_FRAC_BITS;
  localparam int QS_W   = SPB_W - SPB_FRAC_BITS;
  localparam int DVD_W  = SAMPLE_BITS + DIV_W + SPB_FRAC_BITS;
  localparam int CNT_W  = $clog2(DVD_W + 1);
  localparam int CMP_W  = ((FX_W + 1 > SAMPLE_BITS) ? FX_W + 1 : SAMPLE_BITS) + 1;
  localparam int CFG_W  = (SPB_W > SAMPLE_BITS) ? SPB_W : SAMPLE_BITS;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_SPB = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BPB = 2'd2;

  localparam logic [SPB_W-1:0] SPB_RESET = 40'd1572864000;
  localparam logic [BPB_W-1:0] BPB_RESET = 5'd4;

  localparam logic [1:0] KIND_BAR  = 2'd0;
  localparam logic [1:0] KIND_BEAT = 2'd1;
  localparam logic [1:0] KIND_SUB  = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] window_first;
    logic signed [SAMPLE_BITS-1:0] window_last;
    logic [DIV_W-1:0]              division;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] line_sample;
    logic signed [SAMPLE_BITS-1:0] line_index;
    logic [1:0]                    kind;
    logic                          is_last;
    logic                          truncated;
    logic                          empty_res;
  } out_t;

  // Query handed from front to back.
  typedef struct packed {
    logic                   empty;
    logic                   neg;
    logic [SAMPLE_BITS-1:0] first;
    logic [SAMPLE_BITS-1:0] span;
    logic [SAMPLE_BITS-1:0] mag;
    logic [SAMPLE_BITS-1:0] klo;
    logic [DIV_W-1:0]       div;
    logic [BPB_W-1:0]       bpb;
    logic [QS_W-1:0]        qs;
    logic [DEN_W-1:0]       rs;
    logic [FX_W-1:0]        fx0;
    logic [DEN_W-1:0]       rx0;
    logic [BPB_W-1:0]       bq;
    logic [DIV_W-1:0]       sr;
  } cmd_t;

  typedef struct packed {
    logic step;
    logic qbit;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/bgl_fifo.sv =====
// Small register queue used between the block's parts.
// Generic over the item type; uses no package items.
module bgl_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  T     wdata,
  output logic full,
  input  logic pop,
  output T     rdata,
  output logic empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  T                mem_r [DEPTH];
  logic [PW-1:0]   wr_r, rd_r;
  logic [CW-1:0]   cnt_r;
  logic            do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (do_pop) begin
        rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/bgl_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, shared by the front.
// Depends on bgl_pkg.
module bgl_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [bgl_pkg::DVD_W-1:0]           dividend,
  input  logic [bgl_pkg::CNT_W-1:0]           nbits,
  input  logic [bgl_pkg::SPB_W-1:0]           divisor,
  output bgl_pkg::div_stat_t                  stat,
  output logic [bgl_pkg::SAMPLE_BITS-1:0]     quo,
  output logic [bgl_pkg::SPB_W-1:0]           rem
);
  import bgl_pkg::*;

  logic [DVD_W-1:0]       dvd_r;
  logic [SPB_W-1:0]       dsr_r, rem_r;
  logic [SAMPLE_BITS-1:0] quo_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   busy_r, done_r;
  logic [SPB_W:0]         trial, diff;
  logic                   ge;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign ge    = (trial >= {1'b0, dsr_r});
  assign diff  = trial - {1'b0, dsr_r};

  assign stat.step = busy_r;
  assign stat.qbit = ge;
  assign stat.done = done_r;
  assign quo = quo_r;
  assign rem = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend << (CNT_W'(DVD_W) - nbits);
      dsr_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[SPB_W-1:0] : trial[SPB_W-1:0];
      quo_r <= {quo_r[SAMPLE_BITS-2:0], ge};
      dvd_r <= dvd_r << 1;
    end
  end

endmodule

// ===== rtl/bgl_front.sv =====
// Front part: accepts a query, finds the start index and the step constants.
// Depends on bgl_pkg and bgl_div.
module bgl_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_push,
  input  bgl_pkg::in_t                         in_data,
  output logic                                 in_full,
  input  logic [bgl_pkg::SPB_W-1:0]            spb,
  input  logic [bgl_pkg::SAMPLE_BITS-1:0]      org,
  input  logic [bgl_pkg::BPB_W-1:0]            bpb,
  input  logic                                 mid_full,
  output logic                                 mid_push,
  output bgl_pkg::cmd_t                        mid_data
);
  import bgl_pkg::*;

  localparam int S = SAMPLE_BITS;
  localparam int F = SPB_FRAC_BITS;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MUL  = 4'd1;
  localparam logic [3:0] ST_QGO  = 4'd2;
  localparam logic [3:0] ST_QRUN = 4'd3;
  localparam logic [3:0] ST_FIX  = 4'd4;
  localparam logic [3:0] ST_SGO  = 4'd5;
  localparam logic [3:0] ST_SRUN = 4'd6;
  localparam logic [3:0] ST_RGO  = 4'd7;
  localparam logic [3:0] ST_RRUN = 4'd8;
  localparam logic [3:0] ST_BGO  = 4'd9;
  localparam logic [3:0] ST_BRUN = 4'd10;
  localparam logic [3:0] ST_PUSH = 4'd11;

  logic [3:0]         state_r, state_nxt;
  logic               empty_r, neg_r;
  logic [S-1:0]       first_r, span_r, mag_r, klo_r;
  logic [DIV_W-1:0]   div_r, sr_r;
  logic [BPB_W-1:0]   bpb_r, bq_r;
  logic [MOD_W-1:0]   modm_r, qm_r, basem_r;
  logic [SPB_W-1:0]   spb_r, r_r;
  logic [S+DIV_W-1:0] prod_r;
  logic [QS_W-1:0]    qs_r;
  logic [DEN_W-1:0]   rs_r, rx0_r;
  logic [FX_W-1:0]    fx0_r;

  logic               accept;
  logic [DIV_W-1:0]   divq;
  logic [S:0]         dorg;
  logic               dneg;
  logic [S:0]         dabs;
  logic [MOD_W:0]     qm_t;

  logic               div_start;
  logic [DVD_W-1:0]   div_dividend;
  logic [CNT_W-1:0]   div_nbits;
  logic [SPB_W-1:0]   div_divisor;
  div_stat_t          div_stat;
  logic [S-1:0]       div_quo;
  logic [SPB_W-1:0]   div_rem;

  logic               c;
  logic [MOD_W:0]     bm_t;

  bgl_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .nbits    (div_nbits),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  assign in_full  = (state_r != ST_IDLE);
  assign accept   = in_push && !in_full;
  assign mid_push = (state_r == ST_PUSH) && !mid_full;

  assign divq = (in_data.division == '0) ? DIV_W'(1) : in_data.division;
  assign dorg = {in_data.window_first[S-1], in_data.window_first} - {org[S-1], org};
  assign dneg = dorg[S];
  assign dabs = dneg ? -dorg : dorg;

  assign qm_t = {qm_r, div_stat.qbit};
  assign c    = (div_rem != '0);
  assign bm_t = {1'b0, qm_r} + (MOD_W + 1)'(c);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_nbits    = CNT_W'(DVD_W);
    div_divisor  = spb_r;
    case (state_r)
      ST_QGO: begin
        div_start    = 1'b1;
        div_dividend = {prod_r, {F{1'b0}}};
      end
      ST_SGO: begin
        div_start    = 1'b1;
        div_dividend = DVD_W'(spb_r >> F);
        div_nbits    = CNT_W'(QS_W);
        div_divisor  = SPB_W'(div_r);
      end
      ST_RGO: begin
        div_start    = 1'b1;
        div_dividend = DVD_W'(r_r >> F);
        div_nbits    = CNT_W'(QS_W);
        div_divisor  = SPB_W'(div_r);
      end
      ST_BGO: begin
        div_start    = 1'b1;
        div_dividend = DVD_W'(basem_r);
        div_nbits    = CNT_W'(MOD_W);
        div_divisor  = SPB_W'(div_r);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) begin
        state_nxt = (in_data.window_last < in_data.window_first) ? ST_PUSH : ST_MUL;
      end
      ST_MUL:  state_nxt = ST_QGO;
      ST_QGO:  state_nxt = ST_QRUN;
      ST_QRUN: if (div_stat.done) state_nxt = ST_FIX;
      ST_FIX:  state_nxt = ST_SGO;
      ST_SGO:  state_nxt = ST_SRUN;
      ST_SRUN: if (div_stat.done) state_nxt = ST_RGO;
      ST_RGO:  state_nxt = ST_RRUN;
      ST_RRUN: if (div_stat.done) state_nxt = ST_BGO;
      ST_BGO:  state_nxt = ST_BRUN;
      ST_BRUN: if (div_stat.done) state_nxt = ST_PUSH;
      ST_PUSH: if (!mid_full) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: if (accept) begin
        empty_r <= (in_data.window_last < in_data.window_first);
        first_r <= in_data.window_first;
        span_r  <= S'(in_data.window_last - in_data.window_first);
        neg_r   <= dneg;
        mag_r   <= dabs[S-1:0];
        div_r   <= divq;
        bpb_r   <= bpb;
        modm_r  <= MOD_W'(divq) * MOD_W'(bpb);
        spb_r   <= spb;
      end
      ST_MUL:  prod_r <= mag_r * div_r;
      ST_QGO:  qm_r <= '0;
      ST_QRUN: if (div_stat.step) begin
        qm_r <= (qm_t >= {1'b0, modm_r}) ? MOD_W'(qm_t - {1'b0, modm_r}) : qm_t[MOD_W-1:0];
      end
      ST_FIX: begin
        if (!neg_r) begin
          klo_r   <= div_quo + S'(c);
          basem_r <= (bm_t >= {1'b0, modm_r}) ? MOD_W'(bm_t - {1'b0, modm_r})
                                              : bm_t[MOD_W-1:0];
          r_r     <= c ? spb_r - div_rem : '0;
        end else begin
          klo_r   <= -div_quo;
          basem_r <= (qm_r == '0) ? '0 : modm_r - qm_r;
          r_r     <= div_rem;
        end
      end
      ST_SRUN: if (div_stat.done) begin
        qs_r <= div_quo[QS_W-1:0];
        rs_r <= {div_rem[DIV_W-1:0], spb_r[F-1:0]};
      end
      ST_RRUN: if (div_stat.done) begin
        fx0_r <= div_quo[FX_W-1:0];
        rx0_r <= {div_rem[DIV_W-1:0], r_r[F-1:0]};
      end
      ST_BRUN: if (div_stat.done) begin
        bq_r <= div_quo[BPB_W-1:0];
        sr_r <= div_rem[DIV_W-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    mid_data.empty = empty_r;
    mid_data.neg   = neg_r;
    mid_data.first = first_r;
    mid_data.span  = span_r;
    mid_data.mag   = mag_r;
    mid_data.klo   = klo_r;
    mid_data.div   = div_r;
    mid_data.bpb   = bpb_r;
    mid_data.qs    = qs_r;
    mid_data.rs    = rs_r;
    mid_data.fx0   = fx0_r;
    mid_data.rx0   = rx0_r;
    mid_data.bq    = bq_r;
    mid_data.sr    = sr_r;
  end

endmodule

// ===== rtl/bgl_back.sv =====
// Back part: steps through grid lines of one query, one line per cycle while the result queue has room.
// Depends on bgl_pkg.
module bgl_back #(
  parameter int MAX_LINES = bgl_pkg::MAX_LINES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           mid_empty,
  input  bgl_pkg::cmd_t  mid_data,
  output logic           mid_pop,
  input  logic           out_full,
  output logic           out_push,
  output bgl_pkg::out_t  out_data
);
  import bgl_pkg::*;

  localparam int S   = SAMPLE_BITS;
  localparam int F   = SPB_FRAC_BITS;
  localparam int J_W = $clog2(MAX_LINES + 1);

  localparam logic B_IDLE = 1'b0;
  localparam logic B_RUN  = 1'b1;

  logic             state_r;
  cmd_t             c_r;
  logic [FX_W-1:0]  fx_r;
  logic [DEN_W-1:0] rx_r;
  logic [J_W-1:0]   j_r;
  logic [S-1:0]     k_r;
  logic [BPB_W-1:0] beat_r;
  logic [DIV_W-1:0] subd_r;
  out_t             pend_r;

  logic             step;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   tworx, rx_sum;
  logic             vneg, up, ok, carry;
  logic [CMP_W-1:0] off;
  out_t             line, empty_item;

  assign step  = (state_r == B_RUN) && !out_full;
  assign den   = {c_r.div, {F{1'b0}}};
  assign tworx = {rx_r, 1'b0};
  assign vneg  = c_r.neg && (CMP_W'(fx_r) < CMP_W'(c_r.mag));
  assign up    = vneg ? (tworx > {1'b0, den}) : (tworx >= {1'b0, den});
  assign off   = CMP_W'(fx_r) + CMP_W'(up);
  assign ok    = (off <= CMP_W'(c_r.span));

  assign rx_sum = {1'b0, rx_r} + {1'b0, c_r.rs};
  assign carry  = (rx_sum >= {1'b0, den});

  assign mid_pop = (state_r == B_IDLE) && !mid_empty;

  always_comb begin
    line.line_sample = c_r.first + off[S-1:0];
    line.line_index  = k_r;
    if (subd_r != '0) begin
      line.kind = KIND_SUB;
    end else if (beat_r == '0) begin
      line.kind = KIND_BAR;
    end else begin
      line.kind = KIND_BEAT;
    end
    line.is_last   = 1'b0;
    line.truncated = 1'b0;
    line.empty_res = 1'b0;

    empty_item = '0;
    empty_item.is_last   = 1'b1;
    empty_item.empty_res = 1'b1;
  end

  // Hold one line back so its is_last flag is known when it leaves.
  always_comb begin
    out_push = 1'b0;
    out_data = pend_r;
    if (step) begin
      if (c_r.empty || (j_r == '0 && !ok)) begin
        out_push = 1'b1;
        out_data = empty_item;
      end else if (j_r != '0) begin
        out_push = 1'b1;
        if (!(ok && j_r != J_W'(MAX_LINES))) begin
          out_data.is_last   = 1'b1;
          out_data.truncated = ok;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else if (mid_pop) begin
      state_r <= B_RUN;
    end else if (step) begin
      if (c_r.empty || !ok || j_r == J_W'(MAX_LINES)) begin
        state_r <= B_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mid_pop) begin
      c_r    <= mid_data;
      fx_r   <= mid_data.fx0;
      rx_r   <= mid_data.rx0;
      j_r    <= '0;
      k_r    <= mid_data.klo;
      beat_r <= mid_data.bq;
      subd_r <= mid_data.sr;
    end else if (step) begin
      pend_r <= line;
      j_r    <= j_r + 1'b1;
      k_r    <= k_r + 1'b1;
      fx_r   <= fx_r + FX_W'(c_r.qs) + FX_W'(carry);
      rx_r   <= carry ? DEN_W'(rx_sum - {1'b0, den}) : rx_sum[DEN_W-1:0];
      if (subd_r == c_r.div - 1'b1) begin
        subd_r <= '0;
        beat_r <= (beat_r == c_r.bpb - 1'b1) ? '0 : beat_r + 1'b1;
      end else begin
        subd_r <= subd_r + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/beat_grid_line_generator.sv =====
// Beat grid line generator, top level: config registers, front, queues, back.
// Front takes a new query only once it has pushed the last; its 1 bit/cycle divider
// works out 72+24+24+13 quotient bits per query, and reversed windows skip it.
// Back: one line per cycle while the result queue has room, up to MAX_LINES lines
// per query.
// Reset: synchronous active-low rst_n clears queues and control, reloads config defaults.
module beat_grid_line_generator #(
  parameter int MAX_LINES = bgl_pkg::MAX_LINES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  output logic                              in_full,
  input  bgl_pkg::in_t                      in_data,
  input  logic                              out_pop,
  output logic                              out_empty,
  output bgl_pkg::out_t                     out_data,
  input  logic                              cfg_we,
  input  logic [bgl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bgl_pkg::CFG_W-1:0]         cfg_data
);
  import bgl_pkg::*;

  // Configuration registers; the user must write them only while idle, the block itself does not enforce it.
  logic [SPB_W-1:0]       spb_r;
  logic [SAMPLE_BITS-1:0] org_r;
  logic [BPB_W-1:0]       bpb_r;
  logic [SPB_W-1:0]       spb_eff;
  logic [BPB_W-1:0]       bpb_eff;

  // Front to back transaction queue.
  logic mid_push, mid_full, mid_pop, mid_empty;
  cmd_t mid_wdata, mid_rdata;

  // Back to result queue.
  logic out_push, out_full;
  out_t out_wdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spb_r <= SPB_RESET;
      org_r <= '0;
      bpb_r <= BPB_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPB: spb_r <= cfg_data[SPB_W-1:0];
        REG_ORG: org_r <= cfg_data[SAMPLE_BITS-1:0];
        REG_BPB: bpb_r <= cfg_data[BPB_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero tempo acts as its smallest step, one LSB; zero bar length acts as one.
  assign spb_eff = (spb_r == '0) ? SPB_W'(1) : spb_r;
  assign bpb_eff = (bpb_r == '0) ? BPB_W'(1) : bpb_r;

  bgl_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .spb      (spb_eff),
    .org      (org_r),
    .bpb      (bpb_eff),
    .mid_full (mid_full),
    .mid_push (mid_push),
    .mid_data (mid_wdata)
  );

  bgl_fifo #(.T(cmd_t), .DEPTH(FIFO_DEPTH)) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (mid_push),
    .wdata (mid_wdata),
    .full  (mid_full),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .empty (mid_empty)
  );

  bgl_back #(.MAX_LINES(MAX_LINES)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mid_empty (mid_empty),
    .mid_data  (mid_rdata),
    .mid_pop   (mid_pop),
    .out_full  (out_full),
    .out_push  (out_push),
    .out_data  (out_wdata)
  );

  // Result queue parts the back from the consumer's pop.
  bgl_fifo #(.T(out_t), .DEPTH(FIFO_DEPTH)) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (out_push),
    .wdata (out_wdata),
    .full  (out_full),
    .pop   (out_pop),
    .rdata (out_data),
    .empty (out_empty)
  );

endmodule
